FILE: hw/rtl/kls_pkg.sv
`timescale 1ns / 1ps

package kls_pkg;

  localparam int KEY_DEPTH_DEFAULT = 64;
  localparam int KEY_LEN_W         = 7;
  localparam int KEY_IDX_W         = 6;
  localparam int BYTE_W            = 8;
  localparam int PIXEL_W           = 24;
  localparam int NUM_CHAN          = 9;
  localparam int NUM_BITS          = 8;
  localparam int SKIP_W            = 4;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_EMBED   = 2'd1,
    OP_EXTRACT = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  // command from the top level to the key sequencer
  typedef struct packed {
    logic                  accept;
    logic                  restart;
    logic                  load;
    logic                  fetch;
    logic                  hdr;
    logic [KEY_IDX_W-1:0]  idx;
    logic [BYTE_W-1:0]     val;
  } key_cmd_t;

  // key material for one transaction
  typedef struct packed {
    logic                  done;
    logic [SKIP_W-1:0]     skip;
    logic [NUM_BITS-1:0]   sel;
  } key_res_t;

  typedef struct packed {
    logic [BYTE_W-1:0] chan;
    logic              bit_val;
  } lane_out_t;

  // skip channel: key byte mod 8 in header mode, mod 9 otherwise
  // x / 9 == (x * 57) >> 9 for every 8-bit x
  function automatic logic [SKIP_W-1:0] skip_mod(input logic [BYTE_W-1:0] x,
                                                 input logic hdr);
    logic [13:0] prod;
    logic [4:0]  quo;
    logic [7:0]  rem;
    prod = 14'(x) * 14'd57;
    quo  = prod[13:9];
    rem  = x - 8'(8'(quo) * 8'd9);
    if (hdr) begin
      return {1'b0, x[2:0]};
    end
    return rem[SKIP_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/kls_in_if.sv
`timescale 1ns / 1ps

interface kls_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          op;
  logic                                restart_key;
  logic                                header_mode;
  logic [kls_pkg::KEY_IDX_W-1:0]       key_index;
  logic [kls_pkg::BYTE_W-1:0]          key_value;
  logic [kls_pkg::BYTE_W-1:0]          data_byte;
  logic [kls_pkg::PIXEL_W-1:0]         pixel_in_0;
  logic [kls_pkg::PIXEL_W-1:0]         pixel_in_1;
  logic [kls_pkg::PIXEL_W-1:0]         pixel_in_2;

  modport source (
    output valid, op, restart_key, header_mode, key_index, key_value, data_byte,
           pixel_in_0, pixel_in_1, pixel_in_2,
    input  ready
  );

  modport sink (
    input  valid, op, restart_key, header_mode, key_index, key_value, data_byte,
           pixel_in_0, pixel_in_1, pixel_in_2,
    output ready
  );
endinterface

FILE: hw/rtl/kls_out_if.sv
`timescale 1ns / 1ps

interface kls_out_if;
  logic                          valid;
  logic                          ready;
  logic [kls_pkg::PIXEL_W-1:0]   pixel_out_0;
  logic [kls_pkg::PIXEL_W-1:0]   pixel_out_1;
  logic [kls_pkg::PIXEL_W-1:0]   pixel_out_2;
  logic [kls_pkg::BYTE_W-1:0]    recovered_byte;
  logic                          end_of_text;

  modport source (
    output valid, pixel_out_0, pixel_out_1, pixel_out_2, recovered_byte, end_of_text,
    input  ready
  );

  modport sink (
    input  valid, pixel_out_0, pixel_out_1, pixel_out_2, recovered_byte, end_of_text,
    output ready
  );
endinterface

FILE: hw/rtl/kls_key_seq.sv
`timescale 1ns / 1ps

module kls_key_seq #(
  parameter int KEY_DEPTH = kls_pkg::KEY_DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [kls_pkg::KEY_LEN_W-1:0]  cfg_data,
  input  kls_pkg::key_cmd_t              cmd,
  output kls_pkg::key_res_t              res
);

  localparam int ADDR_W = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int LEN_CW = $clog2(KEY_DEPTH + 1);
  localparam int CMP_W  = ((kls_pkg::KEY_LEN_W > LEN_CW) ? kls_pkg::KEY_LEN_W : LEN_CW) + 1;
  localparam int IDX_CW = ((kls_pkg::KEY_IDX_W > LEN_CW) ? kls_pkg::KEY_IDX_W : LEN_CW) + 1;
  localparam int CNT_W  = $clog2(kls_pkg::NUM_CHAN);

  logic [kls_pkg::BYTE_W-1:0]    mem [KEY_DEPTH];
  logic [kls_pkg::KEY_LEN_W-1:0] key_length;
  logic [ADDR_W-1:0]             pos;
  logic [ADDR_W-1:0]             pos_next;
  logic                          fetching;
  logic [CNT_W-1:0]              icnt;
  logic                          rd_vld;
  logic [CNT_W-1:0]              rcnt;
  logic [kls_pkg::BYTE_W-1:0]    rdata;
  logic                          hdr;
  logic [CMP_W-1:0]              eff_len;
  logic [CMP_W-1:0]              pos_inc;
  logic                          load_ok;

  // effective length: 0 acts as 1, clamp at depth
  always_comb begin
    eff_len = CMP_W'(key_length);
    if (key_length == '0) begin
      eff_len = CMP_W'(1);
    end else if (CMP_W'(key_length) > CMP_W'(KEY_DEPTH)) begin
      eff_len = CMP_W'(KEY_DEPTH);
    end
    pos_inc  = CMP_W'(pos) + CMP_W'(1);
    pos_next = (pos_inc >= eff_len) ? '0 : pos_inc[ADDR_W-1:0];
    load_ok  = IDX_CW'(cmd.idx) < IDX_CW'(KEY_DEPTH);
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && cmd.load && load_ok) begin
      mem[ADDR_W'(cmd.idx)] <= cmd.val;
    end
    if (fetching) begin
      rdata <= mem[pos];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_length <= kls_pkg::KEY_LEN_W'(1);
      pos        <= '0;
      fetching   <= 1'b0;
      icnt       <= '0;
      rd_vld     <= 1'b0;
      rcnt       <= '0;
    end else begin
      if (cfg_we) begin
        key_length <= cfg_data;
      end
      rd_vld   <= fetching;
      rcnt     <= icnt;
      if (cmd.accept) begin
        if (cmd.restart) begin
          pos <= '0;
        end
        fetching <= cmd.fetch;
        icnt     <= '0;
      end else if (fetching) begin
        pos  <= pos_next;
        icnt <= icnt + CNT_W'(1);
        if (icnt == CNT_W'(kls_pkg::NUM_CHAN - 1)) begin
          fetching <= 1'b0;
        end
      end
    end
  end

  // key bytes land one per cycle: first the skip channel, then the bit selects
  always_ff @(posedge clk) begin
    if (rst) begin
      res.done <= 1'b0;
    end else begin
      res.done <= rd_vld && (rcnt == CNT_W'(kls_pkg::NUM_CHAN - 1));
    end
    if (cmd.accept) begin
      hdr <= cmd.hdr;
    end
    if (rd_vld) begin
      if (rcnt == '0) begin
        res.skip <= kls_pkg::skip_mod(rdata, hdr);
      end else begin
        res.sel[3'(rcnt - CNT_W'(1))] <= rdata[0];
      end
    end
  end

endmodule

FILE: hw/rtl/kls_lane.sv
`timescale 1ns / 1ps

module kls_lane #(
  parameter int LANE = 0
) (
  input  logic [kls_pkg::BYTE_W-1:0]    chan_in,
  input  logic [kls_pkg::SKIP_W-1:0]    skip,
  input  logic [kls_pkg::NUM_BITS-1:0]  sel,
  input  logic [kls_pkg::BYTE_W-1:0]    data,
  input  logic                          embed,
  output kls_pkg::lane_out_t            lane_out
);

  localparam logic [2:0] IDX_LO = 3'((LANE > 0) ? LANE - 1 : 0);
  localparam logic [2:0] IDX_HI = 3'((LANE < kls_pkg::NUM_BITS) ? LANE : 0);

  logic       skipped;
  logic [2:0] idx;
  logic       bsel;
  logic       dbit;

  always_comb begin
    skipped = (skip == kls_pkg::SKIP_W'(LANE));
    // channels before the skipped one keep their own bit slot
    idx  = (kls_pkg::SKIP_W'(LANE) < skip) ? IDX_HI : IDX_LO;
    bsel = sel[idx];
    dbit = data[idx];
    lane_out.chan    = chan_in;
    lane_out.bit_val = bsel ? chan_in[1] : chan_in[0];
    if (embed && !skipped) begin
      if (bsel) begin
        lane_out.chan[1] = dbit;
      end else begin
        lane_out.chan[0] = dbit;
      end
    end
  end

endmodule

FILE: hw/rtl/kls_merge.sv
`timescale 1ns / 1ps

module kls_merge (
  input  kls_pkg::lane_out_t            lanes [kls_pkg::NUM_CHAN],
  input  logic [kls_pkg::SKIP_W-1:0]    skip,
  input  logic                          extract,
  output logic [kls_pkg::PIXEL_W-1:0]   pixel_0,
  output logic [kls_pkg::PIXEL_W-1:0]   pixel_1,
  output logic [kls_pkg::PIXEL_W-1:0]   pixel_2,
  output logic [kls_pkg::BYTE_W-1:0]    rec,
  output logic                          eot
);

  always_comb begin
    pixel_0 = {lanes[2].chan, lanes[1].chan, lanes[0].chan};
    pixel_1 = {lanes[5].chan, lanes[4].chan, lanes[3].chan};
    pixel_2 = {lanes[8].chan, lanes[7].chan, lanes[6].chan};
    // bit b comes from the b-th channel that is not skipped
    for (int b = 0; b < kls_pkg::NUM_BITS; b++) begin
      rec[b] = (kls_pkg::SKIP_W'(b) < skip) ? lanes[b].bit_val : lanes[b + 1].bit_val;
    end
    if (!extract) begin
      rec = '0;
    end
    eot = extract && (rec == '0);
  end

endmodule

FILE: hw/rtl/keyed_lsb_pixel_stego_unit.sv
`timescale 1ns / 1ps

// Keyed LSB pixel stego unit. Each input transaction either loads one key
// byte (op 0), hides data_byte in three RGB pixels (op 1), recovers a byte
// from them (op 2) or does nothing (op 3); every transaction returns exactly
// one output transaction. An embed or extract reads nine key bytes in order
// from the key store: the first (mod 9, or mod 8 with header_mode) picks the
// channel left alone, the next eight pick bit 0 or bit 1 of each remaining
// channel, data going in LSB first. end_of_text flags a recovered zero byte.
// The key position wraps at key_length (written on cfg_we/cfg_data, reset
// value 1) and is reset by restart_key before the transaction is handled.
// Key entries read before being loaded give undefined results. A load or
// unused op goes from idle through the done state back to idle; an embed or
// extract also passes the fetch state for the nine back-to-back reads of the
// key store plus its registered read. Input is accepted while a finished
// result still waits in the output register.
module keyed_lsb_pixel_stego_unit #(
  parameter int KEY_DEPTH = kls_pkg::KEY_DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [kls_pkg::KEY_LEN_W-1:0]  cfg_data,
  kls_in_if.sink                         in_ch,
  kls_out_if.source                      out_ch
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_FETCH = 3'b010,
    ST_DONE  = 3'b100
  } state_t;

  state_t                       state;
  state_t                       state_next;
  logic                         accept;
  kls_pkg::op_t                 in_op;
  kls_pkg::key_cmd_t            cmd;
  kls_pkg::key_res_t            kres;

  // held transaction
  kls_pkg::op_t                 op;
  logic [kls_pkg::BYTE_W-1:0]   data;
  logic [kls_pkg::PIXEL_W-1:0]  px [3];

  kls_pkg::lane_out_t           lanes [kls_pkg::NUM_CHAN];
  logic [kls_pkg::PIXEL_W-1:0]  m_px0;
  logic [kls_pkg::PIXEL_W-1:0]  m_px1;
  logic [kls_pkg::PIXEL_W-1:0]  m_px2;
  logic [kls_pkg::BYTE_W-1:0]   m_rec;
  logic                         m_eot;
  logic                         out_load;
  logic                         uses_key;

  assign in_op        = kls_pkg::op_t'(in_ch.op);
  assign in_ch.ready  = (state == ST_IDLE) && !rst;
  assign accept       = in_ch.valid && in_ch.ready;
  assign uses_key     = (in_op == kls_pkg::OP_EMBED) || (in_op == kls_pkg::OP_EXTRACT);
  assign out_load     = (state == ST_DONE) && (!out_ch.valid || out_ch.ready);

  always_comb begin
    cmd.accept  = accept;
    cmd.restart = in_ch.restart_key;
    cmd.load    = (in_op == kls_pkg::OP_LOAD);
    cmd.fetch   = uses_key;
    cmd.hdr     = in_ch.header_mode;
    cmd.idx     = in_ch.key_index;
    cmd.val     = in_ch.key_value;
  end

  kls_key_seq #(
    .KEY_DEPTH (KEY_DEPTH)
  ) u_key_seq (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .res      (kres)
  );

  // one lane per channel byte; pixel p holds channels 3p..3p+2
  for (genvar g = 0; g < kls_pkg::NUM_CHAN; g++) begin : g_lane
    kls_lane #(
      .LANE (g)
    ) u_lane (
      .chan_in  (px[g / 3][(g % 3) * kls_pkg::BYTE_W +: kls_pkg::BYTE_W]),
      .skip     (kres.skip),
      .sel      (kres.sel),
      .data     (data),
      .embed    (op == kls_pkg::OP_EMBED),
      .lane_out (lanes[g])
    );
  end

  kls_merge u_merge (
    .lanes   (lanes),
    .skip    (kres.skip),
    .extract (op == kls_pkg::OP_EXTRACT),
    .pixel_0 (m_px0),
    .pixel_1 (m_px1),
    .pixel_2 (m_px2),
    .rec     (m_rec),
    .eot     (m_eot)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = uses_key ? ST_FETCH : ST_DONE;
        end
      end
      ST_FETCH: begin
        if (kres.done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_ch.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op    <= in_op;
      data  <= in_ch.data_byte;
      px[0] <= in_ch.pixel_in_0;
      px[1] <= in_ch.pixel_in_1;
      px[2] <= in_ch.pixel_in_2;
    end
    // loads and unused ops pass the pixels through untouched
    if (out_load) begin
      if ((op == kls_pkg::OP_EMBED) || (op == kls_pkg::OP_EXTRACT)) begin
        out_ch.pixel_out_0    <= m_px0;
        out_ch.pixel_out_1    <= m_px1;
        out_ch.pixel_out_2    <= m_px2;
        out_ch.recovered_byte <= m_rec;
        out_ch.end_of_text    <= m_eot;
      end else begin
        out_ch.pixel_out_0    <= px[0];
        out_ch.pixel_out_1    <= px[1];
        out_ch.pixel_out_2    <= px[2];
        out_ch.recovered_byte <= '0;
        out_ch.end_of_text    <= 1'b0;
      end
    end
  end

endmodule
